### hw/rtl/ffac_pkg.sv
// Shared types and constants for the first-fit allocator with compaction.
package ffac_pkg;

  localparam int MEM_CELLS = 128;
  localparam int ID_BITS   = 16;
  localparam int AMT_W     = 16;
  localparam int CFG_W     = 8;
  localparam int IDX_W     = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
  localparam int CNT_W     = $clog2(MEM_CELLS + 1);
  localparam int CMP_W     = (ID_BITS > AMT_W) ? ID_BITS : AMT_W;

  localparam logic [CFG_W-1:0] CELLS_RESET = CFG_W'(MEM_CELLS);

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_ERASE = 2'd1;

  localparam logic [2:0] ST_ALLOC_OK   = 3'd0;
  localparam logic [2:0] ST_ALLOC_FAIL = 3'd1;
  localparam logic [2:0] ST_ERASE_OK   = 3'd2;
  localparam logic [2:0] ST_ERASE_BAD  = 3'd3;
  localparam logic [2:0] ST_DEFRAG     = 3'd4;

  typedef struct packed {
    logic [1:0]       mode;
    logic [AMT_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [AMT_W-1:0] block_id;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_CLEAR,
    S_DONE
  } state_t;

endpackage

### hw/rtl/first_fit_allocator_compactor_core.sv
// First-fit cell allocator with erase and compaction, one cell per cycle.
// Erase scans every managed cell; defragment scans them, then clears each freed cell;
//   an alloc refused up front goes to the result, else it scans for a fitting gap and fills it.
// Throughput: one request at a time, busy from the transfer until the result strobe.
// Reset (rst_n low, synchronous): all cells free, id counter zero, cell count 128.
// The result is shown for one cycle on out_valid; the receiver cannot stall it.
module first_fit_allocator_compactor_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  ffac_pkg::req_t         in_req,
  output logic                   out_valid,
  output ffac_pkg::rsp_t         out_rsp,
  input  logic                   cfg_we,
  input  logic [ffac_pkg::CFG_W-1:0] cfg_data
);
  import ffac_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   cfg_r;
  logic [CNT_W-1:0]   n_eff;
  logic [ID_BITS-1:0] id_cnt_r, id_cnt_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [AMT_W-1:0]   amount_r, amount_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   run_r, run_nxt;
  logic [IDX_W-1:0]   start_r, start_nxt;
  logic [CNT_W-1:0]   end_r, end_nxt;
  logic [CNT_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic               hit_r, hit_nxt;
  rsp_t               rsp_r, rsp_nxt;

  // read stage: registered from the issue counter
  logic               s_vld_r;
  logic [IDX_W-1:0]   s_idx_r;
  logic               s_own_r;
  logic [ID_BITS-1:0] mem_q_r;

  logic [ID_BITS-1:0] mem [MEM_CELLS];
  logic [MEM_CELLS-1:0] valid_r;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [ID_BITS-1:0] mem_wd;
  logic               val_set, val_clr;
  logic [IDX_W-1:0]   val_idx;

  logic               accept, is_alloc, is_erase, is_defrag;
  logic               issue, scan_done, found, alloc_bad, erase_match;
  logic               fill_last, clr_last;
  logic [CNT_W-1:0]   run_inc;
  logic [IDX_W-1:0]   start_sel;

  always_comb begin
    if (cfg_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(cfg_r) > MEM_CELLS) begin
      n_eff = CNT_W'(MEM_CELLS);
    end else begin
      n_eff = CNT_W'(cfg_r);
    end
  end

  // shared conditions
  always_comb begin
    accept      = start && (state_r == S_IDLE);
    is_defrag   = mode_r[1];
    is_erase    = (mode_r == MODE_ERASE);
    is_alloc    = (mode_r == MODE_ALLOC);
    alloc_bad   = (in_req.amount == '0) || (in_req.amount > AMT_W'(n_eff)) || (id_cnt_r == '1);
    issue       = (state_r == S_SCAN) && (idx_r < n_eff);
    scan_done   = (state_r == S_SCAN) && (idx_r == n_eff) && !s_vld_r;
    run_inc     = run_r + CNT_W'(1);
    start_sel   = (run_r == '0) ? s_idx_r : start_r;
    found       = (state_r == S_SCAN) && s_vld_r && is_alloc && !s_own_r
                  && (AMT_W'(run_inc) >= amount_r);
    erase_match = s_own_r && (CMP_W'(mem_q_r) == CMP_W'(amount_r));
    fill_last   = (wr_ptr_r + CNT_W'(1)) == end_r;
    clr_last    = (wr_ptr_r + CNT_W'(1)) == n_eff;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if ((in_req.mode == MODE_ALLOC) && alloc_bad) state_nxt = S_DONE;
          else state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (found) begin
          state_nxt = S_FILL;
        end else if (scan_done) begin
          if (is_defrag && (wr_ptr_r < n_eff)) state_nxt = S_CLEAR;
          else state_nxt = S_DONE;
        end
      end
      S_FILL: begin
        if (fill_last) state_nxt = S_DONE;
      end
      S_CLEAR: begin
        if (clr_last) state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    id_cnt_nxt = id_cnt_r;
    mode_nxt   = mode_r;
    amount_nxt = amount_r;
    idx_nxt    = idx_r;
    run_nxt    = run_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    wr_ptr_nxt = wr_ptr_r;
    hit_nxt    = hit_r;
    rsp_nxt    = rsp_r;
    mem_we     = 1'b0;
    mem_wa     = wr_ptr_r[IDX_W-1:0];
    mem_wd     = id_cnt_r;
    val_set    = 1'b0;
    val_clr    = 1'b0;
    val_idx    = wr_ptr_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt         = in_req.mode;
          amount_nxt       = in_req.amount;
          idx_nxt          = '0;
          run_nxt          = '0;
          wr_ptr_nxt       = '0;
          hit_nxt          = 1'b0;
          rsp_nxt.status   = ST_ALLOC_FAIL;
          rsp_nxt.block_id = '0;
        end
      end
      S_SCAN: begin
        if (issue) idx_nxt = idx_r + CNT_W'(1);
        if (s_vld_r) begin
          if (is_defrag) begin
            if (s_own_r) begin
              mem_we     = 1'b1;
              mem_wd     = mem_q_r;
              val_set    = 1'b1;
              wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
            end
          end else if (is_erase) begin
            if (erase_match) begin
              val_clr = 1'b1;
              val_idx = s_idx_r;
              hit_nxt = 1'b1;
            end
          end else begin
            if (s_own_r) begin
              run_nxt = '0;
            end else begin
              run_nxt   = run_inc;
              start_nxt = start_sel;
            end
          end
        end
        if (found) begin
          id_cnt_nxt = id_cnt_r + ID_BITS'(1);
          wr_ptr_nxt = CNT_W'(start_sel);
          end_nxt    = CNT_W'(start_sel) + CNT_W'(amount_r);
        end else if (scan_done) begin
          rsp_nxt.block_id = '0;
          if (is_defrag) rsp_nxt.status = ST_DEFRAG;
          else if (is_erase) rsp_nxt.status = hit_r ? ST_ERASE_OK : ST_ERASE_BAD;
          else rsp_nxt.status = ST_ALLOC_FAIL;
        end
      end
      S_FILL: begin
        mem_we     = 1'b1;
        val_set    = 1'b1;
        wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
        if (fill_last) begin
          rsp_nxt.status   = ST_ALLOC_OK;
          rsp_nxt.block_id = AMT_W'(id_cnt_r);
        end
      end
      S_CLEAR: begin
        val_clr    = 1'b1;
        wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
        if (clr_last) begin
          rsp_nxt.status   = ST_DEFRAG;
          rsp_nxt.block_id = '0;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_rsp   = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cfg_r    <= CELLS_RESET;
      id_cnt_r <= '0;
      s_vld_r  <= 1'b0;
      valid_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      id_cnt_r <= id_cnt_nxt;
      s_vld_r  <= issue && (state_nxt == S_SCAN);
      if (cfg_we) cfg_r <= cfg_data;
      if (val_set) valid_r[val_idx] <= 1'b1;
      if (val_clr) valid_r[val_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    amount_r <= amount_nxt;
    idx_r    <= idx_nxt;
    run_r    <= run_nxt;
    start_r  <= start_nxt;
    end_r    <= end_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    hit_r    <= hit_nxt;
    rsp_r    <= rsp_nxt;
    s_idx_r  <= idx_r[IDX_W-1:0];
    s_own_r  <= valid_r[idx_r[IDX_W-1:0]];
  end

  // owner store: a cell whose valid bit is clear reads as free
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[idx_r[IDX_W-1:0]];
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request transfer not followed by busy");

  a_id_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status != ST_ALLOC_OK)) |-> (out_rsp.block_id == '0))
    else $error("block id set on a result other than alloc ok");

  a_ok_has_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status == ST_ALLOC_OK)) |-> (id_cnt_r != '0))
    else $error("alloc ok with id counter at zero");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> ((wr_ptr_r < end_r) && (end_r <= n_eff)))
    else $error("fill pointer outside the managed cells");

endmodule
